// ===== sv/round_robin_task_scheduler_unit_assert.svh =====
// assertion macros used by the ready queue rtl
`ifndef ROUND_ROBIN_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RRTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rrts_pkg.sv =====
// package: types, codes and constants of the round-robin task scheduler
`default_nettype none
package rrts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int ACT_W         = 2;
  localparam int ID_W          = 4;
  localparam int OC_W          = 2;

  typedef enum logic [1:0] {
    ST_FREE      = 2'd0,
    ST_SUSPENDED = 2'd1,
    ST_READY     = 2'd2,
    ST_RUNNING   = 2'd3
  } slot_status_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_YIELD   = 2'd0,
    ACT_RESUME  = 2'd1,
    ACT_SUSPEND = 2'd2,
    ACT_CREATE  = 2'd3
  } action_t;

  typedef enum logic [OC_W-1:0] {
    OC_DONE    = 2'd0,
    OC_IGNORED = 2'd1,
    OC_FAULT   = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_PUSH,
    S_RUN,
    S_DONE
  } sched_state_t;

  // commands from the sequencer to the queue unit
  typedef struct packed {
    logic start;
    logic pop;
    logic push;
  } q_cmd_t;

  // status from the queue unit back to the sequencer
  typedef struct packed {
    logic done;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== sv/rrts_status.sv =====
// slot status store: memory with per-slot valid bits standing in for the reset values
`default_nettype none
module rrts_status
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int IW        = $clog2(MAX_TASKS)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [IW-1:0] rd_addr,
  output slot_status_t       rd_status,
  input  wire logic          wr_en,
  input  wire logic [IW-1:0] wr_addr,
  input  wire slot_status_t  wr_status
);

  slot_status_t         mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] vld_r;
  slot_status_t         rd_data_r;
  slot_status_t         rd_rst_r;
  logic                 rd_vld_r;

  // valid bits, cleared at reset, set by the first write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_status;
    end
  end

  // registered read, with the reset value for slots never written
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
      rd_rst_r  <= (rd_addr == '0) ? ST_RUNNING : ST_FREE;
    end
  end

  assign rd_status = rd_vld_r ? rd_data_r : rd_rst_r;

endmodule
`default_nettype wire

// ===== sv/rrts_queue.sv =====
// ready queue: id memory, fill count and the shared walk unit that finds and closes gaps
`default_nettype none
module rrts_queue
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int IW        = $clog2(MAX_TASKS),
  parameter int CW        = $clog2(MAX_TASKS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire q_cmd_t        cmd,
  input  wire logic [IW-1:0] target,
  input  wire logic [IW-1:0] push_id,
  output q_stat_t            stat,
  output logic      [IW-1:0] head
);

  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TASKS);

  logic [IW-1:0] mem [MAX_TASKS];
  logic [IW-1:0] rd_data_r;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] pidx_r, pidx_nxt;
  logic          pend_r, pend_nxt;
  logic          found_r, found_nxt;
  logic          walk_r, walk_nxt;
  logic          pop_r, pop_nxt;
  logic [IW-1:0] tgt_r, tgt_nxt;
  logic [IW-1:0] head_r, head_nxt;

  logic          issue;
  logic          walk_done;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] wr_data;

  // walk control: one entry read per cycle, compared and shifted in the cycle after its read
  always_comb begin
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    pidx_nxt  = pidx_r;
    pend_nxt  = pend_r;
    found_nxt = found_r;
    walk_nxt  = walk_r;
    pop_nxt   = pop_r;
    tgt_nxt   = tgt_r;
    head_nxt  = head_r;
    rd_en     = 1'b0;
    rd_addr   = idx_r[IW-1:0];
    wr_en     = 1'b0;
    wr_addr   = cnt_r[IW-1:0];
    wr_data   = push_id;
    issue     = walk_r && (idx_r < cnt_r);
    walk_done = walk_r && !issue && !pend_r;

    if (cmd.start) begin
      walk_nxt  = 1'b1;
      idx_nxt   = '0;
      pend_nxt  = 1'b0;
      found_nxt = 1'b0;
      pop_nxt   = cmd.pop;
      tgt_nxt   = target;
    end else if (walk_r) begin
      // issue the next read
      pend_nxt = issue;
      if (issue) begin
        rd_en    = 1'b1;
        pidx_nxt = idx_r[IW-1:0];
        idx_nxt  = idx_r + CW'(1);
      end
      // entry read last cycle: match, or move it down one place
      if (pend_r) begin
        if (found_r) begin
          wr_en   = 1'b1;
          wr_addr = pidx_r - IW'(1);
          wr_data = rd_data_r;
        end else if (pop_r || (rd_data_r == tgt_r)) begin
          found_nxt = 1'b1;
          head_nxt  = rd_data_r;
        end
      end
      if (walk_done) begin
        walk_nxt = 1'b0;
        cnt_nxt  = cnt_r - CW'(found_r);
      end
    end else if (cmd.push && (cnt_r < CNT_MAX)) begin
      // append at the tail, dropped on a full queue
      wr_en   = 1'b1;
      wr_addr = cnt_r[IW-1:0];
      wr_data = push_id;
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      walk_r  <= 1'b0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      walk_r  <= walk_nxt;
      pend_r  <= pend_nxt;
      found_r <= found_nxt;
    end
  end

  // walk payload registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pidx_r <= pidx_nxt;
    pop_r  <= pop_nxt;
    tgt_r  <= tgt_nxt;
    head_r <= head_nxt;
  end

  // queue memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign stat.done  = walk_done;
  assign stat.empty = (cnt_r == '0);
  assign head       = head_r;

`include "round_robin_task_scheduler_unit_assert.svh"

  `RRTS_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CNT_MAX, "ready count above queue depth")
  `RRTS_ASSERT_IMPL(a_start_idle, cmd.start || cmd.push, !walk_r, "queue command during a walk")
  `RRTS_ASSERT_IMPL(a_shift_pos, walk_r && pend_r && found_r, pidx_r != '0,
                    "gap closing below the queue head")
  `RRTS_ASSERT_NEXT(a_done_ends, stat.done, !walk_r, "walk still busy after done")

endmodule
`default_nettype wire

// ===== sv/round_robin_task_scheduler_unit.sv =====
// Round-robin task scheduler: slot statuses, a FIFO ready queue of task ids and the running
// task; each input beat asks to yield, resume, suspend or create, and gives one result beat.
// Resume, create, ignored and faulting requests, and a yield with nothing queued, go from the
// slot status check straight to the output register.
// Suspend of a ready task, yield, and suspend of the running task walk the ready queue through
// its memory, one entry a cycle; a yield then puts the preempted task back at the tail, and both
// yield and running-task suspend make the popped head run. No clearing pass is needed after
// reset. The input is taken again once the result is in the output register.
`default_nettype none
module round_robin_task_scheduler_unit
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] action, [5:2] task_id, [7:6] zero
  input  wire logic [7:0]  in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [3:0] running_task, [7:4] previous_task, [8] switched, [10:9] outcome, [15:11] zero
  output logic [15:0]      out_tdata
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  sched_state_t  state_r, state_nxt;

  action_t       act_r, act_nxt;
  logic [IW-1:0] id_r, id_nxt;
  logic          id_ok_r, id_ok_nxt;
  logic [IW-1:0] prev_r, prev_nxt;
  logic [IW-1:0] running_r, running_nxt;
  outcome_t      outc_r, outc_nxt;
  logic          push_cur_r, push_cur_nxt;
  logic          run_r, run_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [IW-1:0] out_run_r, out_run_nxt;
  logic [IW-1:0] out_prev_r, out_prev_nxt;
  logic          out_sw_r, out_sw_nxt;
  outcome_t      out_oc_r, out_oc_nxt;

  logic          in_acc;
  logic          out_load;
  logic [ACT_W-1:0] in_action;
  logic [ID_W-1:0]  in_task_id;

  // status store ports
  logic          st_rd_en;
  logic [IW-1:0] st_rd_addr;
  slot_status_t  st_rd;
  logic          st_wr_en;
  logic [IW-1:0] st_wr_addr;
  slot_status_t  st_wr;

  // queue unit ports
  q_cmd_t        q_cmd;
  logic [IW-1:0] q_target;
  logic [IW-1:0] q_push_id;
  q_stat_t       q_stat;
  logic [IW-1:0] q_head;

  // decision taken once the slot status is back
  logic          chk_walk;
  logic          chk_pop;
  logic          chk_push_cur;
  logic          chk_st_wr;
  slot_status_t  chk_st;
  logic          chk_q_push;
  outcome_t      chk_outc;

  assign in_action  = in_tdata[1:0];
  assign in_task_id = in_tdata[5:2];
  assign in_acc     = in_tvalid && in_tready;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);

  rrts_status #(
    .MAX_TASKS (MAX_TASKS),
    .IW        (IW)
  ) u_status (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (st_rd_en),
    .rd_addr   (st_rd_addr),
    .rd_status (st_rd),
    .wr_en     (st_wr_en),
    .wr_addr   (st_wr_addr),
    .wr_status (st_wr)
  );

  rrts_queue #(
    .MAX_TASKS (MAX_TASKS),
    .IW        (IW),
    .CW        (CW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (q_cmd),
    .target  (q_target),
    .push_id (q_push_id),
    .stat    (q_stat),
    .head    (q_head)
  );

  // what the request does, given the status of its slot
  always_comb begin
    chk_walk     = 1'b0;
    chk_pop      = 1'b0;
    chk_push_cur = 1'b0;
    chk_st_wr    = 1'b0;
    chk_st       = ST_SUSPENDED;
    chk_q_push   = 1'b0;
    chk_outc     = OC_IGNORED;
    case (act_r)
      ACT_YIELD: begin
        chk_outc = OC_DONE;
        if (!q_stat.empty) begin
          chk_walk     = 1'b1;
          chk_pop      = 1'b1;
          chk_push_cur = 1'b1;
        end
      end
      ACT_RESUME: begin
        if (id_ok_r && (st_rd == ST_SUSPENDED)) begin
          chk_st_wr  = 1'b1;
          chk_st     = ST_READY;
          chk_q_push = 1'b1;
          chk_outc   = OC_DONE;
        end
      end
      ACT_SUSPEND: begin
        if (id_ok_r && (st_rd == ST_READY)) begin
          chk_st_wr = 1'b1;
          chk_walk  = 1'b1;
          chk_outc  = OC_DONE;
        end else if (id_ok_r && (st_rd == ST_RUNNING)) begin
          if (q_stat.empty) begin
            chk_outc = OC_FAULT;
          end else begin
            chk_st_wr = 1'b1;
            chk_walk  = 1'b1;
            chk_pop   = 1'b1;
            chk_outc  = OC_DONE;
          end
        end
      end
      ACT_CREATE: begin
        if (id_ok_r && (st_rd == ST_FREE)) begin
          chk_st_wr = 1'b1;
          chk_outc  = OC_DONE;
        end
      end
      default: begin
        chk_outc = OC_IGNORED;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = chk_walk ? S_WALK : S_DONE;
      end
      S_WALK: begin
        if (q_stat.done) begin
          if (push_cur_r)  state_nxt = S_PUSH;
          else if (run_r)  state_nxt = S_RUN;
          else             state_nxt = S_DONE;
        end
      end
      S_PUSH: begin
        state_nxt = S_RUN;
      end
      S_RUN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs and datapath updates of each state
  always_comb begin
    act_nxt      = act_r;
    id_nxt       = id_r;
    id_ok_nxt    = id_ok_r;
    prev_nxt     = prev_r;
    running_nxt  = running_r;
    outc_nxt     = outc_r;
    push_cur_nxt = push_cur_r;
    run_nxt      = run_r;
    out_run_nxt  = out_run_r;
    out_prev_nxt = out_prev_r;
    out_sw_nxt   = out_sw_r;
    out_oc_nxt   = out_oc_r;
    in_tready    = 1'b0;
    st_rd_en     = 1'b0;
    st_rd_addr   = IW'(in_task_id);
    st_wr_en     = 1'b0;
    st_wr_addr   = id_r;
    st_wr        = ST_SUSPENDED;
    q_cmd        = '0;
    q_target     = id_r;
    q_push_id    = id_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          act_nxt   = action_t'(in_action);
          id_nxt    = IW'(in_task_id);
          id_ok_nxt = (32'(in_task_id) < 32'(MAX_TASKS));
          prev_nxt  = running_r;
          st_rd_en  = 1'b1;
        end
      end
      S_CHECK: begin
        outc_nxt     = chk_outc;
        push_cur_nxt = chk_push_cur;
        run_nxt      = chk_pop;
        st_wr_en     = chk_st_wr;
        st_wr        = chk_st;
        q_cmd.start  = chk_walk;
        q_cmd.pop    = chk_pop;
        q_cmd.push   = chk_q_push;
      end
      S_PUSH: begin
        // preempted task goes back to the tail as ready
        st_wr_en   = 1'b1;
        st_wr_addr = prev_r;
        st_wr      = ST_READY;
        q_cmd.push = 1'b1;
        q_push_id  = prev_r;
      end
      S_RUN: begin
        st_wr_en    = 1'b1;
        st_wr_addr  = q_head;
        st_wr       = ST_RUNNING;
        running_nxt = q_head;
      end
      S_DONE: begin
        if (out_load) begin
          out_run_nxt  = running_r;
          out_prev_nxt = prev_r;
          out_sw_nxt   = (running_r != prev_r);
          out_oc_nxt   = outc_r;
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // output register valid
  always_comb begin
    if (out_load)                       out_valid_nxt = 1'b1;
    else if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    else                                out_valid_nxt = out_valid_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      running_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    id_r       <= id_nxt;
    id_ok_r    <= id_ok_nxt;
    prev_r     <= prev_nxt;
    outc_r     <= outc_nxt;
    push_cur_r <= push_cur_nxt;
    run_r      <= run_nxt;
    out_run_r  <= out_run_nxt;
    out_prev_r <= out_prev_nxt;
    out_sw_r   <= out_sw_nxt;
    out_oc_r   <= out_oc_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_oc_r, out_sw_r, ID_W'(out_prev_r), ID_W'(out_run_r)};

endmodule
`default_nettype wire

// ===== bench/round_robin_task_scheduler_unit_checker.sv =====
// checker for the scheduler: watches both streams, predicts each result beat and compares
module round_robin_task_scheduler_unit_checker
  import rrts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  // [1:0] action, [5:2] task_id, [7:6] zero
  input  wire logic [7:0]  in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  // [3:0] running_task, [7:4] previous_task, [8] switched, [10:9] outcome, [15:11] zero
  input  wire logic [15:0] out_tdata,
  output int               fail_count,
  output int               pending
);

  localparam int SLOTS = MAX_TASKS_DEF;

  typedef struct packed {
    logic [ID_W-1:0] running;
    logic [ID_W-1:0] previous;
    logic            switched;
    outcome_t        outcome;
  } sched_result_t;

  // model of the slot table, the ready fifo and the running slot
  slot_status_t    slot_st [SLOTS];
  logic [ID_W-1:0] ready_q [$];
  logic [ID_W-1:0] run_slot;

  sched_result_t   expected_results [$];
  int              mismatches = 0;

  task automatic report_error(input string what);
    $display("[%0t] scheduler mismatch: %s", $time, what);
    mismatches++;
  endtask

  // hand the slot to the queue head; a preempted task goes back to the tail as ready
  function automatic outcome_t pick_next();
    if (slot_st[run_slot] == ST_SUSPENDED) begin
      if (ready_q.size() == 0) return OC_FAULT;
    end else begin
      if (ready_q.size() == 0) return OC_DONE;
      slot_st[run_slot] = ST_READY;
      ready_q.push_back(run_slot);
    end
    run_slot = ready_q.pop_front();
    slot_st[run_slot] = ST_RUNNING;
    return OC_DONE;
  endfunction

  // apply one request to the model and give the result it should produce
  function automatic sched_result_t schedule_request(input action_t act,
                                                     input logic [ID_W-1:0] id);
    sched_result_t   res;
    logic [ID_W-1:0] prev;
    outcome_t        oc;
    bit              found;
    prev  = run_slot;
    oc    = OC_IGNORED;
    found = 1'b0;
    if (act == ACT_YIELD) begin
      oc = pick_next();
    end else if (int'(id) < SLOTS) begin
      case (act)
        ACT_RESUME: begin
          if (slot_st[id] == ST_SUSPENDED) begin
            slot_st[id] = ST_READY;
            ready_q.push_back(id);
            oc = OC_DONE;
          end
        end
        ACT_SUSPEND: begin
          if (slot_st[id] == ST_READY) begin
            slot_st[id] = ST_SUSPENDED;
            // pull it out of the fifo wherever it stands
            for (int i = 0; i < ready_q.size(); i++) begin
              if (!found && ready_q[i] == id) begin
                ready_q.delete(i);
                found = 1'b1;
              end
            end
            oc = OC_DONE;
          end else if (slot_st[id] == ST_RUNNING) begin
            if (ready_q.size() == 0) begin
              oc = OC_FAULT;
            end else begin
              slot_st[id] = ST_SUSPENDED;
              oc = pick_next();
            end
          end
        end
        default: begin
          if (slot_st[id] == ST_FREE) begin
            slot_st[id] = ST_SUSPENDED;
            oc = OC_DONE;
          end
        end
      endcase
    end
    res.running  = run_slot;
    res.previous = prev;
    res.switched = (run_slot != prev);
    res.outcome  = oc;
    return res;
  endfunction

  // sample both streams at the edge; results first, then the new request
  always @(posedge clk) begin : watch
    sched_result_t want;
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) slot_st[s] = ST_FREE;
      slot_st[0] = ST_RUNNING;
      run_slot   = '0;
      ready_q.delete();
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("result beat %h with nothing expected", out_tdata));
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[3:0] != want.running)
            report_error($sformatf("running_task %0d, expected %0d",
                                   out_tdata[3:0], want.running));
          if (out_tdata[7:4] != want.previous)
            report_error($sformatf("previous_task %0d, expected %0d",
                                   out_tdata[7:4], want.previous));
          if (out_tdata[8] != want.switched)
            report_error($sformatf("switched %0d, expected %0d",
                                   out_tdata[8], want.switched));
          if (out_tdata[10:9] != want.outcome)
            report_error($sformatf("outcome %0d, expected %0d",
                                   out_tdata[10:9], want.outcome));
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(schedule_request(action_t'(in_tdata[1:0]),
                                                    in_tdata[5:2]));
    end
    pending    <= expected_results.size();
    fail_count <= mismatches;
  end

endmodule

// ===== bench/round_robin_task_scheduler_unit_tb.sv =====
// testbench top: clock, reset, request stimulus, result back-pressure and the verdict
module round_robin_task_scheduler_unit_tb
  import rrts_pkg::*;
();

  localparam int RANDOM_BEATS = 1550;
  localparam int DRAIN_AT     = 700;
  localparam int CALM_LO      = 1000;
  localparam int CALM_HI      = 1200;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_LEN     = 300;
  localparam int TAIL_CYCLES  = 40;
  localparam int STALL_LIMIT  = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // [1:0] action, [5:2] task_id, [7:6] zero
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // [3:0] running_task, [7:4] previous_task, [8] switched, [10:9] outcome, [15:11] zero
  logic [15:0] out_tdata;
  int          fail_count;
  int          pending;
  bit          sender_calm;

  always #5 clk = ~clk;

  round_robin_task_scheduler_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  round_robin_task_scheduler_unit_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // offer one request beat, after a random gap, and hold it until taken
  task automatic send_request(input action_t act, input logic [ID_W-1:0] id);
    while (!sender_calm && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, id, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // request stimulus and verdict
  initial begin
    int      r;
    action_t act;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    sender_calm = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle task alone, ignored requests, faults, mid-queue removal, preemption
    send_request(ACT_YIELD,   4'd0);
    send_request(ACT_SUSPEND, 4'd0);
    send_request(ACT_RESUME,  4'd5);
    send_request(ACT_SUSPEND, 4'd5);
    send_request(ACT_CREATE,  4'd15);
    send_request(ACT_CREATE,  4'd15);
    send_request(ACT_SUSPEND, 4'd15);
    send_request(ACT_CREATE,  4'd1);
    send_request(ACT_CREATE,  4'd2);
    send_request(ACT_RESUME,  4'd15);
    send_request(ACT_RESUME,  4'd1);
    send_request(ACT_RESUME,  4'd2);
    send_request(ACT_RESUME,  4'd1);
    send_request(ACT_CREATE,  4'd1);
    send_request(ACT_SUSPEND, 4'd1);
    send_request(ACT_YIELD,   4'd9);
    send_request(ACT_SUSPEND, 4'd15);
    send_request(ACT_CREATE,  4'd0);
    send_request(ACT_SUSPEND, 4'd0);
    send_request(ACT_SUSPEND, 4'd2);
    send_request(ACT_YIELD,   4'd15);
    send_request(ACT_RESUME,  4'd15);
    send_request(ACT_RESUME,  4'd1);
    send_request(ACT_YIELD,   4'd0);
    send_request(ACT_SUSPEND, 4'd2);
    send_request(ACT_SUSPEND, 4'd1);
    send_request(ACT_YIELD,   4'd0);
    wait_for_drain();

    // random mix over all slots
    for (int k = 0; k < RANDOM_BEATS; k++) begin
      if (k == DRAIN_AT) wait_for_drain();
      sender_calm = (k >= CALM_LO && k < CALM_HI);
      r = $urandom_range(99);
      if (r < 30)      act = ACT_YIELD;
      else if (r < 58) act = ACT_RESUME;
      else if (r < 86) act = ACT_SUSPEND;
      else             act = ACT_CREATE;
      send_request(act, 4'($urandom_range(15)));
    end
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("round_robin_task_scheduler_unit_tb passed");
    end else begin
      $display("round_robin_task_scheduler_unit_tb failed");
    end
    $finish;
  end

  // result back-pressure: random stalls, one long hold-off, one calm stretch
  initial begin
    int taken;
    int hold_left;
    bit held;
    taken      = 0;
    hold_left  = 0;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) taken++;
      if (taken == HOLD_AT && !held) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (taken >= CALM_LO && taken < CALM_HI) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 30);
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall = 0;
      else stall++;
    end
    $display("round_robin_task_scheduler_unit_tb failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rrts_pkg.sv
sv/rrts_status.sv
sv/rrts_queue.sv
sv/round_robin_task_scheduler_unit.sv
bench/round_robin_task_scheduler_unit_checker.sv
bench/round_robin_task_scheduler_unit_tb.sv
